>>> hw/rtl/vtpg_pkg.sv
`default_nettype none

package vtpg_pkg;

	// Pattern codes held in the pattern select register
	typedef enum logic [2:0] {
		PAT_GRID  = 3'd0,
		PAT_PLUGE = 3'd1,
		PAT_RAMPS = 3'd2,
		PAT_SMPTE = 3'd3,
		PAT_BLEED = 3'd4
	} pattern_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd2;

	// Geometry
	localparam logic [8:0] ACTIVE_W = 9'd320;
	localparam logic [8:0] LINES_NTSC = 9'd224;
	localparam logic [4:0] GRID_LAST_COL = 5'd19;
	localparam logic [3:0] GRID_LAST_ROW_NTSC = 4'd13;
	localparam logic [3:0] GRID_LAST_ROW_PAL = 4'd15;

	// SMPTE section boundaries and levels
	localparam logic [7:0] SMPTE_TOP_NTSC = 8'd150;
	localparam logic [7:0] SMPTE_TOP_PAL = 8'd171;
	localparam logic [7:0] SMPTE_MID_NTSC = 8'd168;
	localparam logic [7:0] SMPTE_MID_PAL = 8'd192;
	localparam logic [7:0] SMPTE_LVL_75 = 8'd184;
	localparam logic [7:0] SMPTE_LVL_100 = 8'd255;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	localparam rgb_t RGB_BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0};

endpackage

`default_nettype wire

>>> hw/rtl/video_test_pattern_generator_unit.sv
// A request is held in the request register and its colour in the result register.
// Throughput: one pixel per cycle unless the output stalls; a request is accepted
// while the previous colour waits, the input and result registers parting the sides.
// Reset clears the pattern select, PAL and level registers (grid, NTSC, 75 %)
// and empties both registers; colour payload is not reset.
`default_nettype none

module video_test_pattern_generator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel request channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [8:0]                        pixel_x,
	input  wire logic [7:0]                        pixel_y,
	// colour result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [7:0]                             red,
	output logic [7:0]                             green,
	output logic [7:0]                             blue,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [vtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vtpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vtpg_pkg::*;

	// Configuration registers
	pattern_t pattern_q;
	logic     pal_q;
	logic     full_lvl_q;

	// Stage 1: registered request
	logic       v_s1;
	logic [8:0] x_s1;
	logic [7:0] y_s1;

	// Stage 2: registered colour
	logic v_s2;
	rgb_t rgb_s2;

	logic adv_s1;
	logic adv_s2;
	rgb_t rgb_c;

	// True when x lies in [x0, x1) and y in [y0, y1)
	function automatic logic in_rect(input logic [8:0] x, input logic [7:0] y,
			input logic [8:0] x0, input logic [8:0] x1,
			input logic [7:0] y0, input logic [8:0] y1);
		in_rect = (x >= x0) && (x < x1) && (y >= y0) && ({1'b0, y} < y1);
	endfunction

	// ------------------------------------------------------------------
	// Configuration: always ready; writes arrive only while the block idles (the
	// user must keep to this; the block itself does not enforce it)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= PAT_GRID;
			pal_q      <= 1'b0;
			full_lvl_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PATTERN: pattern_q  <= pattern_t'(cfg_data);
				CFG_PAL:     pal_q      <= cfg_data[0];
				CFG_LEVEL:   full_lvl_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: each stage advances when the one after it can take it
	// ------------------------------------------------------------------
	assign adv_s2   = !v_s2 || !out_stall;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
		if (adv_s2 && v_s1) rgb_s2 <= rgb_c;
	end

	// ------------------------------------------------------------------
	// Colour logic, between the request register and the result register
	// ------------------------------------------------------------------
	always_comb begin
		logic       active;
		logic [7:0] ys;
		logic       on_line;
		logic       on_dot;
		logic       outer;
		logic [3:0] last_row;
		logic [7:0] ramp_n;
		logic [7:0] ramp_v;
		logic [2:0] col;
		logic [7:0] top_h;
		logic [7:0] mid_end;
		logic [7:0] lv;

		rgb_c = RGB_BLACK;

		// In PAL the active height is the whole 8-bit range
		active = (x_s1 < ACTIVE_W) && (pal_q || ({1'b0, y_s1} < LINES_NTSC));

		// Shifted line for PLUGE, ramps and bleed; lines above the offset wrap
		// past every element and so stay black
		ys = pal_q ? (y_s1 - 8'd16) : y_s1;

		// Grid: cell edges and the 2x2 centre dot
		on_line  = (x_s1[3:0] == 4'd0) || (x_s1[3:0] == 4'd15)
			|| (y_s1[3:0] == 4'd0) || (y_s1[3:0] == 4'd15);
		on_dot   = ((x_s1[3:0] == 4'd7) || (x_s1[3:0] == 4'd8))
			&& ((y_s1[3:0] == 4'd7) || (y_s1[3:0] == 4'd8));
		last_row = pal_q ? GRID_LAST_ROW_PAL : GRID_LAST_ROW_NTSC;
		outer    = (x_s1[8:4] == 5'd0) || (y_s1[7:4] == 4'd0)
			|| (x_s1[8:4] == GRID_LAST_COL) || (y_s1[7:4] == last_row);

		// Ramps: one step of 0x11 for every 16 pixels from x = 32
		ramp_n = x_s1[7:0] - 8'd32;
		ramp_v = {ramp_n[7:4], ramp_n[7:4]};

		// SMPTE bar column from the bar edges
		if (x_s1 >= 9'd274)      col = 3'd6;
		else if (x_s1 >= 9'd228) col = 3'd5;
		else if (x_s1 >= 9'd183) col = 3'd4;
		else if (x_s1 >= 9'd138) col = 3'd3;
		else if (x_s1 >= 9'd92)  col = 3'd2;
		else if (x_s1 >= 9'd46)  col = 3'd1;
		else                     col = 3'd0;
		top_h   = pal_q ? SMPTE_TOP_PAL : SMPTE_TOP_NTSC;
		mid_end = pal_q ? SMPTE_MID_PAL : SMPTE_MID_NTSC;
		lv      = full_lvl_q ? SMPTE_LVL_100 : SMPTE_LVL_75;

		if (active) begin
			case (pattern_q)
				PAT_GRID: begin
					if (on_line || on_dot) begin
						if (outer)
							rgb_c = '{r: 8'd255, g: 8'd0, b: 8'd0};
						else
							rgb_c = '{r: 8'd255, g: 8'd255, b: 8'd255};
					end
				end
				PAT_PLUGE: begin
					// centre grey stack, then the outer and inner side bars
					if (in_rect(x_s1, ys, 9'd120, 9'd200, 8'd32, 9'd72))
						rgb_c = '{r: 8'd255, g: 8'd255, b: 8'd255};
					else if (in_rect(x_s1, ys, 9'd120, 9'd200, 8'd72, 9'd112))
						rgb_c = '{r: 8'd176, g: 8'd176, b: 8'd176};
					else if (in_rect(x_s1, ys, 9'd120, 9'd200, 8'd112, 9'd152))
						rgb_c = '{r: 8'd72, g: 8'd72, b: 8'd72};
					else if (in_rect(x_s1, ys, 9'd120, 9'd200, 8'd152, 9'd192))
						rgb_c = '{r: 8'd48, g: 8'd48, b: 8'd48};
					else if (in_rect(x_s1, ys, 9'd40, 9'd56, 8'd32, 9'd192)
							|| in_rect(x_s1, ys, 9'd264, 9'd280, 8'd32, 9'd192))
						rgb_c = '{r: 8'd32, g: 8'd32, b: 8'd32};
					else if (in_rect(x_s1, ys, 9'd72, 9'd88, 8'd32, 9'd192)
							|| in_rect(x_s1, ys, 9'd232, 9'd248, 8'd32, 9'd192))
						rgb_c = '{r: 8'd16, g: 8'd16, b: 8'd16};
				end
				PAT_RAMPS: begin
					if (x_s1 >= 9'd32 && x_s1 < 9'd288) begin
						if (ys >= 8'd40 && ys < 8'd72)
							rgb_c = '{r: ramp_v, g: 8'd0, b: 8'd0};
						else if (ys >= 8'd80 && ys < 8'd112)
							rgb_c = '{r: 8'd0, g: ramp_v, b: 8'd0};
						else if (ys >= 8'd120 && ys < 8'd152)
							rgb_c = '{r: 8'd0, g: 8'd0, b: ramp_v};
						else if (ys >= 8'd160 && ys < 8'd192)
							rgb_c = '{r: ramp_v, g: ramp_v, b: ramp_v};
					end
				end
				PAT_SMPTE: begin
					if (y_s1 < top_h) begin
						// grey, yellow, cyan, green, magenta, red, blue
						case (col)
							3'd0:    rgb_c = '{r: lv, g: lv, b: lv};
							3'd1:    rgb_c = '{r: lv, g: lv, b: 8'd0};
							3'd2:    rgb_c = '{r: 8'd0, g: lv, b: lv};
							3'd3:    rgb_c = '{r: 8'd0, g: lv, b: 8'd0};
							3'd4:    rgb_c = '{r: lv, g: 8'd0, b: lv};
							3'd5:    rgb_c = '{r: lv, g: 8'd0, b: 8'd0};
							default: rgb_c = '{r: 8'd0, g: 8'd0, b: lv};
						endcase
					end else if (y_s1 < mid_end) begin
						// reverse blue bars, near-black between them
						case (col)
							3'd0:    rgb_c = '{r: 8'd0, g: 8'd0, b: 8'd184};
							3'd2:    rgb_c = '{r: 8'd184, g: 8'd0, b: 8'd184};
							3'd4:    rgb_c = '{r: 8'd0, g: 8'd188, b: 8'd184};
							3'd6:    rgb_c = '{r: 8'd184, g: 8'd188, b: 8'd184};
							default: rgb_c = '{r: 8'd8, g: 8'd12, b: 8'd8};
						endcase
					end else begin
						// -I, white, +Q, black and the PLUGE steps
						if (x_s1 < 9'd60)
							rgb_c = '{r: 8'd0, g: 8'd32, b: 8'd72};
						else if (x_s1 < 9'd120)
							rgb_c = '{r: 8'd248, g: 8'd252, b: 8'd248};
						else if (x_s1 < 9'd180)
							rgb_c = '{r: 8'd48, g: 8'd0, b: 8'd96};
						else if (x_s1 < 9'd240)
							rgb_c = '{r: 8'd8, g: 8'd12, b: 8'd8};
						else if (x_s1 < 9'd255)
							rgb_c = '{r: 8'd0, g: 8'd4, b: 8'd0};
						else if (x_s1 < 9'd272)
							rgb_c = '{r: 8'd8, g: 8'd12, b: 8'd8};
						else if (x_s1 < 9'd287)
							rgb_c = '{r: 8'd16, g: 8'd20, b: 8'd16};
						else
							rgb_c = '{r: 8'd8, g: 8'd12, b: 8'd8};
					end
				end
				PAT_BLEED: begin
					// stripes on every even column from 16 to 302
					if (x_s1 >= 9'd16 && x_s1 <= 9'd302 && !x_s1[0]) begin
						if (ys >= 8'd40 && ys < 8'd72)
							rgb_c = '{r: 8'd240, g: 8'd0, b: 8'd0};
						else if (ys >= 8'd80 && ys < 8'd112)
							rgb_c = '{r: 8'd0, g: 8'd244, b: 8'd0};
						else if (ys >= 8'd120 && ys < 8'd152)
							rgb_c = '{r: 8'd0, g: 8'd0, b: 8'd240};
						else if (ys >= 8'd160 && ys < 8'd192)
							rgb_c = '{r: 8'd240, g: 8'd244, b: 8'd240};
					end
				end
				default: rgb_c = RGB_BLACK;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result channel
	// ------------------------------------------------------------------
	assign out_valid = v_s2;
	assign red       = rgb_s2.r;
	assign green     = rgb_s2.g;
	assign blue      = rgb_s2.b;

endmodule

`default_nettype wire
